### hw/rtl/msp_pkg.sv
`default_nettype none

package msp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_W      = 28;
    localparam int CONS_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODES   = 1'b1;

    localparam logic [3:0] PACKET_TYPE_RST = 4'd9;
    localparam logic [7:0] MAX_CODES_RST   = 8'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_TYPE     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_VARNUM   = 3'd4,
        ST_ARRAY    = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0] packet_type;
        logic [7:0] max_codes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } rx_item_t;

endpackage

`default_nettype wire

### hw/rtl/msp_rx_if.sv
`default_nettype none

interface msp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/msp_result_if.sv
`default_nettype none

interface msp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] msg_id;
    logic [1:0]  granted_qos;
    logic [8:0]  bytes_consumed;

    modport source (output valid, output status, output msg_id, output granted_qos,
                    output bytes_consumed, input ready);
    modport sink   (input valid, input status, input msg_id, input granted_qos,
                    input bytes_consumed, output ready);
endinterface

`default_nettype wire

### hw/rtl/msp_cfg_if.sv
`default_nettype none

interface msp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/msp_cfg_regs.sv
`default_nettype none

module msp_cfg_regs
    import msp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    msp_cfg_if.sink   cfg,
    output cfg_t      cfg_q
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packet_type <= PACKET_TYPE_RST;
            cfg_reg.max_codes   <= MAX_CODES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PACKET_TYPE: cfg_reg.packet_type <= cfg.data[3:0];
                CFG_MAX_CODES:   cfg_reg.max_codes   <= cfg.data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/msp_in_reg.sv
`default_nettype none

module msp_in_reg
    import msp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    msp_rx_if.sink    rx,
    input  wire logic take,
    output logic      item_valid,
    output rx_item_t  item
);

    logic     valid_reg;
    rx_item_t item_reg;

    assign rx.ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    // hold the payload until the core takes it
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            item_reg.data_byte  <= rx.data_byte;
            item_reg.buffer_end <= rx.buffer_end;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/msp_core.sv
`default_nettype none

module msp_core
    import msp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg_q,
    input  wire logic     item_valid,
    input  wire rx_item_t item,
    output logic          take,
    msp_result_if.source  result
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_ID_HI,
        PH_ID_LO,
        PH_CODES,
        PH_DRAIN
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [2:0]        lbc_reg, lbc_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [7:0]        codes_reg, codes_next;
    logic [15:0]       id_reg, id_next;
    logic [1:0]        qos_reg, qos_next;
    logic [CONS_W-1:0] cons_reg, cons_next;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [15:0]       pid_reg, pid_next;
    logic [1:0]        gqos_reg, gqos_next;
    logic [CONS_W-1:0] bcons_reg, bcons_next;

    logic              emit;
    logic [LEN_W-1:0]  shifted;
    logic [7:0]        b;
    logic              at_end;

    assign b      = item.data_byte;
    assign at_end = item.buffer_end;
    assign take   = item_valid && (!out_valid_reg || result.ready);

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.msg_id         = pid_reg;
    assign result.granted_qos    = gqos_reg;
    assign result.bytes_consumed = bcons_reg;

    always_comb
    begin
        case (lbc_reg[1:0])
            2'd0:    shifted = {21'd0, b[6:0]};
            2'd1:    shifted = {14'd0, b[6:0], 7'd0};
            2'd2:    shifted = {7'd0, b[6:0], 14'd0};
            default: shifted = {b[6:0], 21'd0};
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        lbc_next    = lbc_reg;
        left_next   = left_reg;
        codes_next  = codes_reg;
        id_next     = id_reg;
        qos_next    = qos_reg;
        cons_next   = cons_reg;
        emit        = 1'b0;
        status_next = ST_OK;
        pid_next    = 16'd0;
        gqos_next   = 2'd0;
        bcons_next  = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                acc_next   = '0;
                lbc_next   = 3'd0;
                left_next  = '0;
                codes_next = 8'd0;
                id_next    = 16'd0;
                qos_next   = 2'd0;
                cons_next  = CONS_W'(1);
                if (b[7:4] != cfg_q.packet_type)
                begin
                    emit        = 1'b1;
                    status_next = ST_TYPE;
                end
                else if (at_end)
                begin
                    emit        = 1'b1;
                    status_next = ST_SHORT;
                end
                else
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                acc_next  = acc_reg | shifted;
                lbc_next  = lbc_reg + 3'd1;
                cons_next = cons_reg + CONS_W'(1);
                if (b[7])
                begin
                    if (lbc_next >= 3'd4)
                    begin
                        emit        = 1'b1;
                        status_next = ST_VARNUM;
                    end
                    else if (at_end)
                    begin
                        emit        = 1'b1;
                        status_next = ST_SHORT;
                    end
                end
                else if (acc_next < LEN_W'(3))
                begin
                    emit        = 1'b1;
                    status_next = ST_MISMATCH;
                end
                else if (at_end)
                begin
                    emit        = 1'b1;
                    status_next = ST_SHORT;
                end
                else
                begin
                    left_next  = acc_next;
                    phase_next = PH_ID_HI;
                end
            end
            PH_ID_HI:
            begin
                id_next   = {b, 8'd0};
                left_next = left_reg - LEN_W'(1);
                if (at_end)
                begin
                    emit        = 1'b1;
                    status_next = ST_SHORT;
                end
                else
                begin
                    phase_next = PH_ID_LO;
                end
            end
            PH_ID_LO:
            begin
                id_next   = {id_reg[15:8], b};
                left_next = left_reg - LEN_W'(1);
                if (codes_reg >= cfg_q.max_codes)
                begin
                    emit        = 1'b1;
                    status_next = ST_ARRAY;
                end
                else if (at_end)
                begin
                    emit        = 1'b1;
                    status_next = ST_SHORT;
                end
                else
                begin
                    phase_next = PH_CODES;
                end
            end
            PH_CODES:
            begin
                qos_next   = (b <= 8'd2) ? b[1:0] : 2'd3;
                codes_next = codes_reg + 8'd1;
                left_next  = left_reg - LEN_W'(1);
                if (left_next == '0)
                begin
                    emit        = 1'b1;
                    status_next = ST_OK;
                    pid_next    = id_reg;
                    gqos_next   = qos_next;
                    bcons_next  = cons_reg + acc_reg[CONS_W-1:0];
                    phase_next  = PH_HEADER;
                end
                else if (codes_next >= cfg_q.max_codes)
                begin
                    emit        = 1'b1;
                    status_next = ST_ARRAY;
                end
                else if (at_end)
                begin
                    emit        = 1'b1;
                    status_next = ST_SHORT;
                end
            end
            PH_DRAIN:
            begin
                if (at_end)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        // drop to drain after an error unless the buffer ends here
        if (emit && status_next != ST_OK)
        begin
            phase_next = at_end ? PH_HEADER : PH_DRAIN;
        end

        if (take)
        begin
            out_valid_next = emit;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            acc_reg       <= '0;
            lbc_reg       <= 3'd0;
            left_reg      <= '0;
            codes_reg     <= 8'd0;
            id_reg        <= 16'd0;
            qos_reg       <= 2'd0;
            cons_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            pid_reg       <= 16'd0;
            gqos_reg      <= 2'd0;
            bcons_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                lbc_reg   <= lbc_next;
                left_reg  <= left_next;
                codes_reg <= codes_next;
                id_reg    <= id_next;
                qos_reg   <= qos_next;
                cons_reg  <= cons_next;
                if (emit)
                begin
                    status_reg <= status_next;
                    pid_reg    <= pid_next;
                    gqos_reg   <= gqos_next;
                    bcons_reg  <= bcons_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mqtt_suback_parser.sv
// SUBACK parser: takes a receive buffer one byte per transfer on rx
// (data_byte, buffer_end marks the last byte) and gives at most one
// result per byte on result: status, msg_id, granted_qos and
// bytes_consumed. Success is reported on the last return code byte;
// any error is reported once, then bytes are dropped up to the next
// buffer_end, after which a header byte is expected again.
// Configuration writes on cfg (index 0: expected packet type, index 1:
// most return codes) are always ready and must be done while idle.
// A byte passes through one input register and one result register.
// Throughput: one byte per cycle while the receiver takes results.
// Reset clears the parse state to "expecting header", empties both
// registers and restores the register defaults (type 9, two codes).
// When the receiver stalls, the pending result holds, the core stops and
// rx.ready drops as soon as the input register holds a byte.
`default_nettype none

module mqtt_suback_parser
    import msp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    msp_rx_if.sink       rx,
    msp_result_if.source result,
    msp_cfg_if.sink      cfg
);

    cfg_t     cfg_q;
    logic     item_valid;
    rx_item_t item;
    logic     take;

    msp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    msp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    msp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_q),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .result     (result)
    );

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> item_valid)
        else $error("core took a byte from an empty input register");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !take) |=> (item_valid && $stable(item)))
        else $error("buffered byte changed while waiting for the core");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK)
            |-> (result.msg_id == 16'd0 && result.granted_qos == 2'd0
                 && result.bytes_consumed == 9'd0))
        else $error("error result carries nonzero fields");

    a_no_take_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !take)
        else $error("core advanced while the result register was stalled");

endmodule

`default_nettype wire

### tb/mqtt_suback_parser_checker.sv
`default_nettype none

module mqtt_suback_parser_checker
    import msp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rx_valid,
    input  wire logic                  rx_ready,
    input  wire logic [7:0]            rx_data_byte,
    input  wire logic                  rx_buffer_end,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire logic [2:0]            result_status,
    input  wire logic [15:0]           result_msg_id,
    input  wire logic [1:0]            result_granted_qos,
    input  wire logic [8:0]            result_bytes_consumed,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending
);

    typedef enum logic [2:0] {
        WAIT_HEADER,
        READ_LENGTH,
        READ_ID_HI,
        READ_ID_LO,
        READ_CODES,
        SKIP_TO_END
    } parse_phase_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] msg_id;
        logic [1:0]  qos;
        logic [8:0]  consumed;
    } suback_ack_t;

    logic [3:0]   want_type;
    logic [7:0]   code_limit;
    parse_phase_t ph;
    logic [27:0]  len_acc;
    logic [2:0]   len_bytes;
    logic [27:0]  remaining;
    logic [7:0]   codes_seen;
    logic [15:0]  ack_id;
    logic [1:0]   qos;
    logic [8:0]   consumed;

    suback_ack_t  expected_acks[$];
    int           errors_found;

    task automatic decode_rx_byte(input logic [7:0] b, input logic last,
                                  output bit emitted, output suback_ack_t ack);
        logic [27:0] chunk;
        status_t     err;
        bit          failed;
        begin
            emitted = 1'b0;
            failed  = 1'b0;
            err     = ST_OK;
            ack     = '0;
            case (ph)
                READ_LENGTH:
                begin
                    chunk     = 28'(b[6:0]) << (7 * len_bytes[1:0]);
                    len_acc   = len_acc | chunk;
                    len_bytes = len_bytes + 3'd1;
                    consumed  = consumed + 9'd1;
                    if (b[7])
                    begin
                        if (len_bytes >= 3'd4)
                        begin
                            failed = 1'b1;
                            err    = ST_VARNUM;
                        end
                        else if (last)
                        begin
                            failed = 1'b1;
                            err    = ST_SHORT;
                        end
                    end
                    else if (len_acc < 28'd3)
                    begin
                        failed = 1'b1;
                        err    = ST_MISMATCH;
                    end
                    else if (last)
                    begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end
                    else
                    begin
                        remaining = len_acc;
                        ph        = READ_ID_HI;
                    end
                end
                READ_ID_HI:
                begin
                    ack_id    = {b, 8'h00};
                    remaining = remaining - 28'd1;
                    if (last)
                    begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end
                    else
                        ph = READ_ID_LO;
                end
                READ_ID_LO:
                begin
                    ack_id    = ack_id | {8'h00, b};
                    remaining = remaining - 28'd1;
                    if (codes_seen >= code_limit)
                    begin
                        failed = 1'b1;
                        err    = ST_ARRAY;
                    end
                    else if (last)
                    begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end
                    else
                        ph = READ_CODES;
                end
                READ_CODES:
                begin
                    qos        = (b <= 8'd2) ? b[1:0] : 2'd3;
                    codes_seen = codes_seen + 8'd1;
                    remaining  = remaining - 28'd1;
                    if (remaining == 28'd0)
                    begin
                        emitted      = 1'b1;
                        ack.status   = ST_OK;
                        ack.msg_id   = ack_id;
                        ack.qos      = qos;
                        ack.consumed = consumed + len_acc[8:0];
                        ph           = WAIT_HEADER;
                    end
                    else if (codes_seen >= code_limit)
                    begin
                        failed = 1'b1;
                        err    = ST_ARRAY;
                    end
                    else if (last)
                    begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end
                end
                SKIP_TO_END:
                begin
                    if (last)
                        ph = WAIT_HEADER;
                end
                default:
                begin
                    len_acc    = '0;
                    len_bytes  = '0;
                    remaining  = '0;
                    codes_seen = '0;
                    ack_id     = '0;
                    qos        = '0;
                    consumed   = 9'd1;
                    if (b[7:4] != want_type)
                    begin
                        failed = 1'b1;
                        err    = ST_TYPE;
                    end
                    else if (last)
                    begin
                        failed = 1'b1;
                        err    = ST_SHORT;
                    end
                    else
                        ph = READ_LENGTH;
                end
            endcase
            if (failed)
            begin
                ph         = last ? WAIT_HEADER : SKIP_TO_END;
                emitted    = 1'b1;
                ack.status = err;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        suback_ack_t exp_ack;
        suback_ack_t new_ack;
        bit          has_ack;
        if (!rst_n)
        begin
            want_type    = PACKET_TYPE_RST;
            code_limit   = MAX_CODES_RST;
            ph           = WAIT_HEADER;
            len_acc      = '0;
            len_bytes    = '0;
            remaining    = '0;
            codes_seen   = '0;
            ack_id       = '0;
            qos          = '0;
            consumed     = '0;
            expected_acks.delete();
            errors_found = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_acks.size() == 0)
                begin
                    errors_found++;
                    if (errors_found <= 10)
                        $display("unexpected result: status %0d id %h qos %0d consumed %0d",
                                 result_status, result_msg_id, result_granted_qos,
                                 result_bytes_consumed);
                end
                else
                begin
                    exp_ack = expected_acks.pop_front();
                    if (exp_ack.status != status_t'(result_status) ||
                        exp_ack.msg_id != result_msg_id ||
                        exp_ack.qos != result_granted_qos ||
                        exp_ack.consumed != result_bytes_consumed)
                    begin
                        errors_found++;
                        if (errors_found <= 10)
                        begin
                            $write("result mismatch: expected status %0d id %h qos %0d consumed %0d",
                                   exp_ack.status, exp_ack.msg_id, exp_ack.qos,
                                   exp_ack.consumed);
                            $display(", got status %0d id %h qos %0d consumed %0d",
                                     result_status, result_msg_id,
                                     result_granted_qos, result_bytes_consumed);
                        end
                    end
                end
            end
            if (rx_valid && rx_ready)
            begin
                decode_rx_byte(rx_data_byte, rx_buffer_end, has_ack, new_ack);
                if (has_ack)
                    expected_acks.push_back(new_ack);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PACKET_TYPE)
                    want_type = cfg_data[3:0];
                else if (cfg_index == CFG_MAX_CODES)
                    code_limit = cfg_data[7:0];
            end
            mismatches <= errors_found;
            pending    <= expected_acks.size();
        end
    end

endmodule

`default_nettype wire

### tb/mqtt_suback_parser_test.sv
`default_nettype none

module mqtt_suback_parser_test;
    import msp_pkg::*;

    typedef enum int {
        PKT_GOOD,
        PKT_EXTRA_CODES,
        PKT_BAD_TYPE,
        PKT_CUT,
        PKT_SHORT_LEN,
        PKT_LEN_OVERFLOW,
        PKT_HUGE_LEN,
        PKT_NOISE
    } pkt_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    int         mismatches;
    int         pending;
    bit         send_gaps;
    bit         recv_gaps;
    bit         hold_request;
    int         bytes_sent;
    logic [3:0] cur_type;
    logic [7:0] cur_max;
    logic [8:0] burst[$];

    msp_rx_if     rx_ch();
    msp_result_if res_ch();
    msp_cfg_if    cfg_ch();

    mqtt_suback_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    mqtt_suback_parser_checker u_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .rx_valid              (rx_ch.valid),
        .rx_ready              (rx_ch.ready),
        .rx_data_byte          (rx_ch.data_byte),
        .rx_buffer_end         (rx_ch.buffer_end),
        .result_valid          (res_ch.valid),
        .result_ready          (res_ch.ready),
        .result_status         (res_ch.status),
        .result_msg_id         (res_ch.msg_id),
        .result_granted_qos    (res_ch.granted_qos),
        .result_bytes_consumed (res_ch.bytes_consumed),
        .cfg_valid             (cfg_ch.valid),
        .cfg_ready             (cfg_ch.ready),
        .cfg_index             (cfg_ch.index),
        .cfg_data              (cfg_ch.data),
        .mismatches            (mismatches),
        .pending               (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #3_200_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int gap;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                recv_gaps = !recv_gaps;
            gap = recv_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid && !hold_request)
                @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid      <= 1'b1;
        rx_ch.data_byte  <= b;
        rx_ch.buffer_end <= last;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[i])
            send_byte(burst[i][7:0], burst[i][8]);
        burst.delete();
    endtask

    task automatic push_length(input int unsigned len, input int pad);
        int n;
        n = 1;
        while (n < 4 && (len >> (7 * n)) != 0)
            n++;
        n = (n + pad > 4) ? 4 : n + pad;
        for (int i = 0; i < n; i++)
            burst.push_back({1'b0, 1'(i < n - 1), 7'((len >> (7 * i)) & 32'h7f)});
    endtask

    task automatic push_suback(input logic [3:0] ptype, input int unsigned len, input int ncodes);
        int pad;
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        burst.push_back({1'b0, ptype, 4'($urandom)});
        push_length(len, pad);
        burst.push_back({1'b0, 8'($urandom)});
        burst.push_back({1'b0, 8'($urandom)});
        repeat (ncodes)
            burst.push_back({1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(0, 2))});
    endtask

    function automatic int good_code_count();
        if (cur_max == 8'd0)
            return 1;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(1, cur_max);
        return $urandom_range(1, (cur_max < 8'd4) ? cur_max : 4);
    endfunction

    task automatic send_random_packet();
        int        n;
        int        pick;
        pkt_kind_t kind;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            kind = PKT_GOOD;
        else if (pick < 63)
            kind = PKT_EXTRA_CODES;
        else if (pick < 70)
            kind = PKT_BAD_TYPE;
        else if (pick < 80)
            kind = PKT_CUT;
        else if (pick < 86)
            kind = PKT_SHORT_LEN;
        else if (pick < 90)
            kind = PKT_LEN_OVERFLOW;
        else if (pick < 93)
            kind = PKT_HUGE_LEN;
        else
            kind = PKT_NOISE;
        case (kind)
            PKT_GOOD:
            begin
                n = good_code_count();
                push_suback(cur_type, 2 + n, n);
                burst[burst.size() - 1][8] = ($urandom_range(0, 3) == 0);
            end
            PKT_EXTRA_CODES:
            begin
                n = cur_max + $urandom_range(1, 3);
                push_suback(cur_type, 2 + n, n);
                burst[burst.size() - 1][8] = 1'b1;
            end
            PKT_BAD_TYPE:
            begin
                burst.push_back({1'b0, cur_type ^ 4'($urandom_range(1, 15)), 4'($urandom)});
                repeat ($urandom_range(0, 3))
                    burst.push_back({1'b0, 8'($urandom)});
                burst[burst.size() - 1][8] = 1'b1;
            end
            PKT_CUT:
            begin
                n = good_code_count();
                push_suback(cur_type, 2 + n, n);
                n = $urandom_range(1, burst.size() - 1);
                while (burst.size() > n)
                    void'(burst.pop_back());
                burst[burst.size() - 1][8] = 1'b1;
            end
            PKT_SHORT_LEN:
            begin
                burst.push_back({1'b0, cur_type, 4'($urandom)});
                push_length($urandom_range(0, 2), $urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1)
                    burst.push_back({1'b0, 8'($urandom)});
                burst[burst.size() - 1][8] = 1'b1;
            end
            PKT_LEN_OVERFLOW:
            begin
                burst.push_back({1'b0, cur_type, 4'($urandom)});
                repeat (4)
                    burst.push_back({1'b0, 1'b1, 7'($urandom)});
                repeat ($urandom_range(0, 2))
                    burst.push_back({1'b0, 8'($urandom)});
                burst[burst.size() - 1][8] = 1'b1;
            end
            PKT_HUGE_LEN:
            begin
                push_suback(cur_type, $urandom_range(300, 28'hFFFFFFF), cur_max + 1);
                burst[burst.size() - 1][8] = 1'b1;
            end
            default:
            begin
                repeat ($urandom_range(1, 4))
                    burst.push_back(9'($urandom));
            end
        endcase
        send_burst();
    endtask

    task automatic run_traffic(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if ($urandom_range(0, 15) == 0)
                send_gaps = !send_gaps;
            send_random_packet();
        end
        // close the buffer so the parser is back at a header
        send_byte(8'($urandom), 1'b1);
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [3:0] ptype, input logic [7:0] max_codes);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PACKET_TYPE;
        cfg_ch.data  <= {4'($urandom), ptype};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_MAX_CODES;
        cfg_ch.data  <= max_codes;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_type = ptype;
        cur_max  = max_codes;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        rx_ch.valid      <= 1'b0;
        rx_ch.data_byte  <= '0;
        rx_ch.buffer_end <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_PACKET_TYPE;
        cfg_ch.data      <= '0;
        cur_type   = PACKET_TYPE_RST;
        cur_max    = MAX_CODES_RST;
        send_gaps  = 1'b1;
        bytes_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst = '{9'h090, 9'h003, 9'h012, 9'h034, 9'h001,
                  9'h09F, 9'h004, 9'h0FF, 9'h0FF, 9'h000, 9'h180,
                  9'h130,
                  9'h090, 9'h102,
                  9'h090, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
                  9'h090, 9'h005, 9'h000, 9'h001, 9'h002, 9'h002, 9'h101,
                  9'h190};
        send_burst();
        run_traffic(250);
        settle();

        apply_config(4'($urandom), 8'd1);
        run_traffic(250);
        settle();

        apply_config(4'hF, 8'd255);
        run_traffic(300);
        settle();

        apply_config(4'h0, 8'd1);
        run_traffic(250);
        settle();

        apply_config(4'($urandom), 8'd0);
        run_traffic(120);
        settle();

        // stall the result side while bytes keep coming
        apply_config(4'($urandom), 8'($urandom_range(1, 255)));
        send_gaps    = 1'b0;
        hold_request = 1'b1;
        run_traffic(300);
        settle();

        apply_config(PACKET_TYPE_RST, 8'd3);
        run_traffic(250);
        settle();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### mqtt_suback_parser.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_rx_if.sv
hw/rtl/msp_result_if.sv
hw/rtl/msp_cfg_if.sv
hw/rtl/msp_cfg_regs.sv
hw/rtl/msp_in_reg.sv
hw/rtl/msp_core.sv
hw/rtl/mqtt_suback_parser.sv
tb/mqtt_suback_parser_checker.sv
tb/mqtt_suback_parser_test.sv
